// ===== rtl/core/cyseg_pkg.sv =====
package cyseg_pkg;

  localparam int MAX_TRANSFER_BYTES = 4096;
  localparam int OUT_DEPTH_DEF      = 4;

  localparam int NODE_ID_W    = 7;
  localparam int SUBJECT_ID_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int LEN_W        = 13;
  localparam int CAN_ID_W     = 29;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_NODE_ID    = 1'b0,
    CFG_SUBJECT_ID = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CAN_ID_W-1:0] can_id;
    logic [63:0]         frame_data;
    logic [3:0]          byte_count;
    logic                run_last;
  } frame_t;

  typedef struct packed {
    logic [1:0] cnt;
    frame_t     f0;
    frame_t     f1;
  } push_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] make_tail(input logic stt, input logic fin, input logic tog,
                                           input logic [4:0] xid);
    return {stt, fin, tog, xid};
  endfunction

  function automatic frame_t make_frame(input logic [CAN_ID_W-1:0] id, input logic [55:0] body,
                                        input logic [2:0] nbytes, input logic [7:0] tail,
                                        input logic last);
    frame_t f;
    f.can_id     = id;
    f.frame_data = {8'h00, body} | ({56'h0, tail} << {nbytes, 3'b000});
    f.byte_count = {1'b0, nbytes} + 4'd1;
    f.run_last   = last;
    return f;
  endfunction

endpackage

// ===== rtl/core/cyseg_in_if.sv =====
interface cyseg_in_if
  import cyseg_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [2:0]       priority_req;
  logic [LEN_W-1:0] transfer_length;
  logic [7:0]       data_byte;

  modport source (output valid, output cmd, output priority_req, output transfer_length,
                  output data_byte, input ready);
  modport sink (input valid, input cmd, input priority_req, input transfer_length,
                input data_byte, output ready);
endinterface

// ===== rtl/core/cyseg_out_if.sv =====
interface cyseg_out_if
  import cyseg_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CAN_ID_W-1:0] can_id;
  logic [63:0]         frame_data;
  logic [3:0]          byte_count;
  logic                run_last;

  modport source (output valid, output can_id, output frame_data, output byte_count,
                  output run_last, input ready);
  modport sink (input valid, input can_id, input frame_data, input byte_count,
                input run_last, output ready);
endinterface

// ===== rtl/core/cyseg_out_fifo.sv =====
module cyseg_out_fifo
  import cyseg_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  push_t         push,
  output logic          room_two,
  cyseg_out_if.source   out_ch
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wr1, wr2;
  logic            pop;
  frame_t          head;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr1  = ptr_inc(wr_ptr_r);
  assign wr2  = ptr_inc(wr1);
  assign pop  = out_ch.valid & out_ch.ready;
  assign room_two = (count_r <= CW'(DEPTH - 2));

  always_comb begin
    case (push.cnt)
      2'd1:    wr_ptr_nxt = wr1;
      2'd2:    wr_ptr_nxt = wr2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.f0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr1] <= push.f1;
    end
  end

  assign head              = mem[rd_ptr_r];
  assign out_ch.valid      = (count_r != '0);
  assign out_ch.can_id     = head.can_id;
  assign out_ch.frame_data = head.frame_data;
  assign out_ch.byte_count = head.byte_count;
  assign out_ch.run_last   = head.run_last;

endmodule

// ===== rtl/core/cyphal_can_transfer_segmenter.sv =====
// Splits a message transfer into classic CAN frames with tail bytes; a
// multi-frame transfer also gets a trailing CRC-16/CCITT. Each item is fully
// handled in the cycle it is accepted, and its frames enter a registered
// output queue of OUT_DEPTH frames. The input is ready whenever the queue
// has room for two frames, so the sustained rate is one item per cycle as
// long as the output keeps up; an item that closes a transfer with two
// frames pushes both at once, which the queue absorbs.
// Configuration writes take effect on the next start item.
module cyphal_can_transfer_segmenter
  import cyseg_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cyseg_in_if.sink              in_ch,
  cyseg_out_if.source           out_ch
);

  logic [4:0]              xfer_id_r, xfer_id_nxt;
  logic                    toggle_r, toggle_nxt;
  logic [LEN_W-1:0]        bytes_left_r, bytes_left_nxt;
  logic [55:0]             slot_r, slot_nxt;
  logic [2:0]              fill_r, fill_nxt;
  logic [15:0]             crc_r, crc_nxt;
  logic                    active_r, active_nxt;
  logic                    first_r, first_nxt;
  logic [CAN_ID_W-1:0]     frame_id_r, frame_id_nxt;
  logic [NODE_ID_W-1:0]    node_id_r;
  logic [SUBJECT_ID_W-1:0] subject_id_r;

  logic                    room_two;
  logic                    accept;
  push_t                   push;
  logic [LEN_W-1:0]        len_sat;
  logic [4:0]              xfer_inc;
  logic [CAN_ID_W-1:0]     id_new;
  logic [55:0]             slot_new;
  logic [2:0]              p;
  logic [15:0]             crc_new;
  logic [15:0]             crc_sw;
  logic [LEN_W-1:0]        bl_new;

  assign in_ch.ready = room_two;
  assign accept      = in_ch.valid & room_two;

  always_comb begin
    if ({3'b000, in_ch.transfer_length} > 16'(MAX_TRANSFER_BYTES)) begin
      len_sat = LEN_W'(MAX_TRANSFER_BYTES);
    end else begin
      len_sat = in_ch.transfer_length;
    end
  end

  assign xfer_inc = xfer_id_r + 5'd1;
  assign id_new   = {in_ch.priority_req, 3'b000, 2'b11, subject_id_r, 1'b0, node_id_r};
  assign slot_new = slot_r | (56'(in_ch.data_byte) << {fill_r, 3'b000});
  assign p        = fill_r + 3'd1;
  assign crc_new  = crc_byte(crc_r, in_ch.data_byte);
  assign crc_sw   = {crc_new[7:0], crc_new[15:8]};
  assign bl_new   = bytes_left_r - LEN_W'(1);

  always_comb begin
    xfer_id_nxt    = xfer_id_r;
    toggle_nxt     = toggle_r;
    bytes_left_nxt = bytes_left_r;
    slot_nxt       = slot_r;
    fill_nxt       = fill_r;
    crc_nxt        = crc_r;
    active_nxt     = active_r;
    first_nxt      = first_r;
    frame_id_nxt   = frame_id_r;
    push           = '0;

    if (accept) begin
      if (in_ch.cmd == CMD_START) begin
        xfer_id_nxt  = xfer_inc;
        frame_id_nxt = id_new;
        toggle_nxt   = 1'b1;
        slot_nxt     = '0;
        fill_nxt     = '0;
        crc_nxt      = CRC_INIT;
        first_nxt    = 1'b1;
        if (len_sat == '0) begin
          push.cnt       = 2'd1;
          push.f0        = make_frame(id_new, 56'h0, 3'd0,
                                      make_tail(1'b1, 1'b1, 1'b1, xfer_inc), 1'b1);
          toggle_nxt     = 1'b0;
          first_nxt      = 1'b0;
          active_nxt     = 1'b0;
          bytes_left_nxt = '0;
        end else begin
          bytes_left_nxt = len_sat;
          active_nxt     = 1'b1;
        end
      end else if (active_r) begin
        slot_nxt       = slot_new;
        fill_nxt       = p;
        crc_nxt        = crc_new;
        bytes_left_nxt = bl_new;
        if (bl_new == '0) begin
          active_nxt = 1'b0;
          slot_nxt   = '0;
          fill_nxt   = '0;
          first_nxt  = 1'b0;
          if (first_r) begin
            push.cnt   = 2'd1;
            push.f0    = make_frame(frame_id_r, slot_new, p,
                                    make_tail(1'b1, 1'b1, toggle_r, xfer_id_r), 1'b1);
            toggle_nxt = ~toggle_r;
          end else if (p <= 3'd5) begin
            push.cnt   = 2'd1;
            push.f0    = make_frame(frame_id_r, slot_new | (56'(crc_sw) << {p, 3'b000}),
                                    p + 3'd2,
                                    make_tail(1'b0, 1'b1, toggle_r, xfer_id_r), 1'b1);
            toggle_nxt = ~toggle_r;
          end else if (p == 3'd6) begin
            push.cnt = 2'd2;
            push.f0  = make_frame(frame_id_r, slot_new | {crc_new[15:8], 48'h0}, 3'd7,
                                  make_tail(1'b0, 1'b0, toggle_r, xfer_id_r), 1'b0);
            push.f1  = make_frame(frame_id_r, 56'(crc_new[7:0]), 3'd1,
                                  make_tail(1'b0, 1'b1, ~toggle_r, xfer_id_r), 1'b1);
          end else begin
            push.cnt = 2'd2;
            push.f0  = make_frame(frame_id_r, slot_new, 3'd7,
                                  make_tail(1'b0, 1'b0, toggle_r, xfer_id_r), 1'b0);
            push.f1  = make_frame(frame_id_r, 56'(crc_sw), 3'd2,
                                  make_tail(1'b0, 1'b1, ~toggle_r, xfer_id_r), 1'b1);
          end
        end else if (p == 3'd7) begin
          push.cnt   = 2'd1;
          push.f0    = make_frame(frame_id_r, slot_new, 3'd7,
                                  make_tail(first_r, 1'b0, toggle_r, xfer_id_r), 1'b1);
          slot_nxt   = '0;
          fill_nxt   = '0;
          toggle_nxt = ~toggle_r;
          first_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xfer_id_r    <= 5'h1F;
      toggle_r     <= 1'b1;
      bytes_left_r <= '0;
      slot_r       <= '0;
      fill_r       <= '0;
      crc_r        <= CRC_INIT;
      active_r     <= 1'b0;
      first_r      <= 1'b1;
      frame_id_r   <= '0;
    end else begin
      xfer_id_r    <= xfer_id_nxt;
      toggle_r     <= toggle_nxt;
      bytes_left_r <= bytes_left_nxt;
      slot_r       <= slot_nxt;
      fill_r       <= fill_nxt;
      crc_r        <= crc_nxt;
      active_r     <= active_nxt;
      first_r      <= first_nxt;
      frame_id_r   <= frame_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= '0;
      subject_id_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NODE_ID:    node_id_r    <= cfg_wdata[NODE_ID_W-1:0];
        CFG_SUBJECT_ID: subject_id_r <= cfg_wdata[SUBJECT_ID_W-1:0];
        default: ;
      endcase
    end
  end

  cyseg_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room_two (room_two),
    .out_ch   (out_ch)
  );

endmodule
